[rtl/agc_pkg.sv]
// Shared types and constants for the attack/release gain control block.
// Used by agc_cfg, agc_ctrl, agc_dp and agc_attack_release_limiter.
`timescale 1ns / 1ps

package agc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CEIL_W   = 15;
    localparam int QUO_W    = 28;           // target << 12
    localparam int REM_W    = 17;
    localparam int BITS_PER_STEP = 2;
    localparam int DIV_STEPS = QUO_W / BITS_PER_STEP;
    localparam int CNT_W    = $clog2(DIV_STEPS);
    localparam int ACC_W    = 33;
    localparam int PROD_W   = 48;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;
    localparam logic [GAIN_W-1:0] GAIN_FLOOR = 16'd410;
    localparam logic [15:0]       ENV_MIN    = 16'd6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAXGAIN = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 8'd5;

    typedef struct packed {
        logic [15:0]       target_level;
        logic [15:0]       max_gain;
        logic [15:0]       trim_gain;
        logic [CEIL_W-1:0] ceiling_level;
        logic [15:0]       attack_coeff;
        logic [15:0]       release_coeff;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CLAMP,
        S_SMA,
        S_SMB,
        S_UPD,
        S_TRIM,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic clamp;
        logic smooth_a;
        logic smooth_b;
        logic update;
        logic trim;
        logic emit;
    } t_cmd;

endpackage

[rtl/agc_cfg.sv]
// Configuration register file for the gain control block.
// Depends on agc_pkg.
`timescale 1ns / 1ps

module agc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [agc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [agc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output agc_pkg::t_cfg                  o_cfg
);
    import agc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_level  <= 16'd16384;
            r_cfg.max_gain      <= 16'd16384;
            r_cfg.trim_gain     <= 16'd4096;
            r_cfg.ceiling_level <= 15'd32767;
            r_cfg.attack_coeff  <= 16'd65000;
            r_cfg.release_coeff <= 16'd65500;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TARGET:  r_cfg.target_level  <= i_cfg_data;
                REG_MAXGAIN: r_cfg.max_gain      <= i_cfg_data;
                REG_TRIM:    r_cfg.trim_gain     <= i_cfg_data;
                REG_CEILING: r_cfg.ceiling_level <= i_cfg_data[CEIL_W-1:0];
                REG_ATTACK:  r_cfg.attack_coeff  <= i_cfg_data;
                REG_RELEASE: r_cfg.release_coeff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/agc_ctrl.sv]
// Sequencer for the gain control block: handshakes and datapath commands.
// Depends on agc_pkg.
`timescale 1ns / 1ps

module agc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output agc_pkg::t_cmd o_cmd
);
    import agc_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;
    logic             div_last;

    assign out_free = !r_out_valid || i_out_ready;
    assign div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) n_state = S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (div_last) n_state = S_CLAMP;
            end
            S_CLAMP: n_state = S_SMA;
            S_SMA:   n_state = S_SMB;
            S_SMB:   n_state = S_UPD;
            S_UPD:   n_state = S_TRIM;
            S_TRIM:  n_state = S_FIN;
            S_FIN: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DIV:   o_cmd.div_step = 1'b1;
            S_CLAMP: o_cmd.clamp    = 1'b1;
            S_SMA:   o_cmd.smooth_a = 1'b1;
            S_SMB:   o_cmd.smooth_b = 1'b1;
            S_UPD:   o_cmd.update   = 1'b1;
            S_TRIM:  o_cmd.trim     = 1'b1;
            S_FIN: begin
                o_cmd.emit = out_free;
                if (out_free) n_out_valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/agc_dp.sv]
// Datapath: radix-4 restoring divider, gain clamp, one-pole smoother,
// sample gain/trim multiplies, rounding and ceiling clip. Depends on agc_pkg.
`timescale 1ns / 1ps

module agc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  agc_pkg::t_cmd                 i_cmd,
    input  agc_pkg::t_cfg                 i_cfg,
    input  logic signed [agc_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic [15:0]                   i_envelope,
    output logic signed [agc_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic [agc_pkg::GAIN_W-1:0]    o_current_gain
);
    import agc_pkg::*;

    logic [SAMPLE_W-1:0] r_mag;
    logic                r_neg;
    logic [15:0]         r_env;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [QUO_W-1:0]    r_quo, n_quo;
    logic [GAIN_W-1:0]   r_desired, n_desired;
    logic [16:0]         r_cinv;
    logic [ACC_W-1:0]    r_acc;
    logic [GAIN_W-1:0]   r_gain;
    logic [PROD_W-1:0]   r_prod;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic [GAIN_W-1:0]   r_out_gain;

    logic [SAMPLE_W-1:0] in_mag;
    logic [15:0]         coeff;
    logic [GAIN_W-1:0]   new_gain;
    logic [PROD_W-1:0]   rounded;
    logic [23:0]         out_mag;
    logic [CEIL_W-1:0]   lim_mag;
    logic [SAMPLE_W-1:0] signed_res;

    assign in_mag = i_sample_in[SAMPLE_W-1] ? (~i_sample_in + 1'b1) : i_sample_in;

    // two quotient bits per cycle
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            n_rem = {n_rem[REM_W-2:0], n_quo[QUO_W-1]};
            n_quo = {n_quo[QUO_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_env}) begin
                n_rem    = n_rem - {1'b0, r_env};
                n_quo[0] = 1'b1;
            end
        end
    end

    // tiny envelope means unity gain, then clamp to [0.1, max_gain]
    always_comb begin
        if (r_env <= ENV_MIN) begin
            n_desired = GAIN_UNITY;
            if (GAIN_UNITY > i_cfg.max_gain) n_desired = i_cfg.max_gain;
        end else if (r_quo < QUO_W'(GAIN_FLOOR)) begin
            n_desired = GAIN_FLOOR;
        end else if (r_quo > QUO_W'(i_cfg.max_gain)) begin
            n_desired = i_cfg.max_gain;
        end else begin
            n_desired = r_quo[GAIN_W-1:0];
        end
    end

    assign coeff    = (r_desired > r_gain) ? i_cfg.attack_coeff : i_cfg.release_coeff;
    assign new_gain = r_acc[31:16];

    assign rounded = r_prod + PROD_W'(1 << 23);
    assign out_mag = rounded[47:24];
    assign lim_mag = (out_mag > 24'(i_cfg.ceiling_level)) ? i_cfg.ceiling_level
                                                           : out_mag[CEIL_W-1:0];
    assign signed_res = r_neg ? (~{1'b0, lim_mag} + 1'b1) : {1'b0, lim_mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_UNITY;
        end else if (i_cmd.update) begin
            r_gain <= new_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= in_mag;
            r_neg <= i_sample_in[SAMPLE_W-1];
            r_env <= i_envelope;
            r_rem <= '0;
            r_quo <= {i_cfg.target_level, 12'd0};
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (i_cmd.clamp) r_desired <= n_desired;
        if (i_cmd.smooth_a) begin
            r_acc  <= ACC_W'(coeff * r_gain);
            r_cinv <= 17'h10000 - {1'b0, coeff};
        end
        if (i_cmd.smooth_b) begin
            r_acc <= r_acc + ACC_W'(r_cinv * r_desired) + ACC_W'(32768);
        end
        if (i_cmd.update) r_prod <= PROD_W'(r_mag * new_gain);
        if (i_cmd.trim)   r_prod <= PROD_W'(r_prod[31:0] * i_cfg.trim_gain);
        if (i_cmd.emit) begin
            r_out_sample <= signed_res;
            r_out_gain   <= r_gain;
        end
    end

    assign o_sample_out   = r_out_sample;
    assign o_current_gain = r_out_gain;

endmodule

[rtl/agc_attack_release_limiter.sv]
// Automatic gain control with attack/release smoothing and output ceiling.
// One input item (sample, envelope) gives one result item (sample, gain).
// An item passes from acceptance to the result register through the accept
// state, the radix-4 restoring divider that forms target/envelope, and the
// steps for clamp, two smoothing multiplies, gain and trim multiplies and
// the final clip. Unless the output stalls, the divider sets the rate;
// the next item is accepted while a finished result still waits on the
// output. Configuration writes are taken at any time but must only be made
// while no item is in flight. Depends on agc_pkg, agc_cfg, agc_ctrl, agc_dp.
`timescale 1ns / 1ps

module agc_attack_release_limiter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,   // [15:0] sample_in, [31:16] envelope
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,   // [15:0] sample_out, [31:16] current_gain
    input  logic                           i_cfg_we,
    input  logic [agc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [agc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import agc_pkg::*;

    t_cfg  cfg;
    t_cmd  cmd;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [GAIN_W-1:0]          current_gain;

    agc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    agc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    agc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg          (cfg),
        .i_sample_in    (s_axis_tdata[15:0]),
        .i_envelope     (s_axis_tdata[31:16]),
        .o_sample_out   (sample_out),
        .o_current_gain (current_gain)
    );

    assign m_axis_tdata = {current_gain, sample_out};

endmodule
